[src/page_bitmap_allocator_defines.svh]
// assertion macros shared by the allocator rtl
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define PBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pba_pkg.sv]
`timescale 1ns / 1ps

package pba_pkg;

    // defaults for the top level parameters
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    // fixed field widths
    localparam int ADDR_W   = 32;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int CNT_W    = 6;

    localparam logic [COUNT_W-1:0] PAGE_LIMIT_RESET = 16'd32768;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RESERVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_RES_SETUP,
        S_RES_RD,
        S_RES_CHK,
        S_RESP
    } state_t;

    // word scan results
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] low_clear;
        logic [CNT_W-1:0] new_count;
    } word_info_t;

endpackage

[src/pba_word_unit.sv]
`timescale 1ns / 1ps

module pba_word_unit
    import pba_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] mask,
    output word_info_t        info
);

    logic [WORD_W-1:0] fresh;
    logic [1:0]        sum1 [16];
    logic [2:0]        sum2 [8];
    logic [3:0]        sum3 [4];
    logic [4:0]        sum4 [2];
    logic [BIT_W-1:0]  low_idx;

    // lowest clear bit of the word
    always_comb
    begin
        low_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                low_idx = BIT_W'(i);
            end
        end
    end

    // count of masked bits that are still clear, adder tree
    assign fresh = mask & ~word;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sum1[i] = {1'b0, fresh[2*i]} + {1'b0, fresh[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            sum2[i] = {1'b0, sum1[2*i]} + {1'b0, sum1[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            sum3[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            sum4[i] = {1'b0, sum3[2*i]} + {1'b0, sum3[2*i+1]};
        end
    end

    assign info.found     = ~&word;
    assign info.low_clear = low_idx;
    assign info.new_count = {1'b0, sum4[0]} + {1'b0, sum4[1]};

endmodule

[src/page_bitmap_allocator.sv]
// page bitmap allocator: one used bit per physical page plus a free page count
// input channel (in_valid/in_ready): req_type, byte_address, region_length
//   allocate returns the lowest free page address, free releases one page,
//   reserve marks every managed page touched by a byte region as used
// output channel (out_valid/out_ready): page_address, status, free_count,
//   used_count, exactly one transaction per request
// config channel (cfg_valid/cfg_ready): cfg_data is the managed page count,
//   always ready, write only while no request is in flight
// one request at a time; the bitmap lives in a single-port-write memory of
// 32-bit words with a registered read; each word takes a read and a check state
//   free: one word (none when ignored), allocate: words scanned from the
//   lowest until a clear bit or the end of the managed pages,
//   reserve: every word touched by the region
// reset: the bitmap is swept to all used, one word per cycle, with in_ready
//   low meanwhile; the free count resets to zero, so software frees the
//   usable pages
// a stalled receiver holds one finished result in the output register; the
// next request is accepted and worked on, and waits only to deliver
`timescale 1ns / 1ps
`include "page_bitmap_allocator_defines.svh"

module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TYPE_W-1:0]   req_type,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [ADDR_W-1:0]   region_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   page_address,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  free_count,
    output logic [COUNT_W-1:0]  used_count
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int EXT_W     = ADDR_W + 2;
    localparam logic [EXT_W-1:0] PAGE_MASK = EXT_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [EXT_W-1:0] PAGES_MAX = EXT_W'(NUM_PAGES);
    localparam logic [WIDX_W:0]  LAST_WORD = (WIDX_W + 1)'(MAP_WORDS - 1);
    localparam logic [WIDX_W:0]  WORD_ONE  = (WIDX_W + 1)'(1);
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    state_t               state_reg, state_next;
    logic [WIDX_W:0]      word_reg, word_next;
    logic [EXT_W-1:0]     pos_reg, pos_next;
    logic [EXT_W-1:0]     last_reg, last_next;
    logic [ADDR_W:0]      sum_reg, sum_next;
    logic [WORD_W-1:0]    mask_reg, mask_next;
    logic [COUNT_W-1:0]   free_reg, free_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [COUNT_W-1:0]   page_limit_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    page_address_reg, page_address_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0]   free_count_reg, free_count_next;
    logic [COUNT_W-1:0]   used_count_reg, used_count_next;

    logic [WORD_W-1:0]    bitmap_mem [MAP_WORDS];
    logic [WORD_W-1:0]    rdata_reg;
    logic                 mem_we;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_data;

    word_info_t           info;
    logic [EXT_W-1:0]     lim_ext;
    logic [EXT_W-1:0]     tp_ext;
    logic [EXT_W-1:0]     word_base;
    logic [EXT_W-1:0]     alloc_page;
    logic [EXT_W-1:0]     free_page;
    logic [EXT_W-1:0]     pos_base;
    logic [EXT_W-1:0]     next_base;
    logic [EXT_W-1:0]     res_end;
    logic [EXT_W-1:0]     res_last;
    logic [EXT_W-1:0]     rem;
    logic [WIDX_W-1:0]    pos_word;
    logic [WORD_W-1:0]    lo_mask;
    logic [WORD_W-1:0]    hi_mask;
    logic [COUNT_W-1:0]   add_count;

    // managed page limit, clipped at the bitmap size
    assign tp_ext  = EXT_W'(page_limit_reg);
    assign lim_ext = (tp_ext > PAGES_MAX) ? PAGES_MAX : tp_ext;

    // address helpers for the word walk
    assign word_base  = EXT_W'({word_reg, {BIT_W{1'b0}}});
    assign alloc_page = EXT_W'({word_reg[WIDX_W-1:0], info.low_clear});
    assign free_page  = EXT_W'(byte_address >> PAGE_SHIFT);
    assign pos_word   = pos_reg[WIDX_W+BIT_W-1:BIT_W];
    assign pos_base   = {pos_reg[EXT_W-1:BIT_W], {BIT_W{1'b0}}};
    assign next_base  = pos_base + EXT_W'(WORD_W);
    assign res_end    = (EXT_W'(sum_reg) + PAGE_MASK) >> PAGE_SHIFT;
    assign res_last   = (res_end > lim_ext) ? lim_ext : res_end;
    assign rem        = last_reg - pos_base;
    assign lo_mask    = {WORD_W{1'b1}} << pos_reg[BIT_W-1:0];
    assign hi_mask    = (rem >= EXT_W'(WORD_W)) ? {WORD_W{1'b1}}
                        : ((WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1));
    assign add_count  = COUNT_W'(info.new_count);

    // shared word scan and count unit
    pba_word_unit u_word
    (
        .word (rdata_reg),
        .mask (mask_reg),
        .info (info)
    );

    // bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= bitmap_mem[rd_addr];
    end

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_limit_reg <= PAGE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            page_limit_reg <= cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            word_reg      <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg          <= pos_next;
        last_reg         <= last_next;
        sum_reg          <= sum_next;
        mask_reg         <= mask_next;
        res_addr_reg     <= res_addr_next;
        res_status_reg   <= res_status_next;
        page_address_reg <= page_address_next;
        status_reg       <= status_next;
        free_count_reg   <= free_count_next;
        used_count_reg   <= used_count_next;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        word_next         = word_reg;
        pos_next          = pos_reg;
        last_next         = last_reg;
        sum_next          = sum_reg;
        mask_next         = mask_reg;
        free_next         = free_reg;
        res_addr_next     = res_addr_reg;
        res_status_next   = res_status_reg;
        page_address_next = page_address_reg;
        status_next       = status_reg;
        free_count_next   = free_count_reg;
        used_count_next   = used_count_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mem_we            = 1'b0;
        rd_addr           = '0;
        wr_addr           = '0;
        wr_data           = '0;

        case (state_reg)
            // sweep the bitmap to all used after reset
            S_CLEAR:
            begin
                mem_we  = 1'b1;
                wr_addr = word_reg[WIDX_W-1:0];
                wr_data = {WORD_W{1'b1}};
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WORD_ONE;
                end
            end

            // decode a new transaction
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_IGNORED;
                    state_next      = S_RESP;
                    case (req_type)
                        REQ_ALLOC:
                        begin
                            if (free_reg == '0)
                            begin
                                res_status_next = ST_NO_PAGE;
                            end
                            else
                            begin
                                word_next  = '0;
                                state_next = S_ALLOC_RD;
                            end
                        end
                        REQ_FREE:
                        begin
                            pos_next = free_page;
                            if (byte_address != '0 && free_page < lim_ext)
                            begin
                                state_next = S_FREE_RD;
                            end
                        end
                        REQ_RESERVE:
                        begin
                            pos_next   = free_page;
                            sum_next   = {1'b0, byte_address} + {1'b0, region_length};
                            state_next = S_RES_SETUP;
                        end
                        default:
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    endcase
                end
            end

            // allocate: stop once the word is past the managed pages
            S_ALLOC_RD:
            begin
                rd_addr = word_reg[WIDX_W-1:0];
                if (word_base >= lim_ext)
                begin
                    res_status_next = ST_NO_PAGE;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_ALLOC_CHK;
                end
            end

            S_ALLOC_CHK:
            begin
                if (info.found && alloc_page < lim_ext)
                begin
                    mem_we          = 1'b1;
                    wr_addr         = word_reg[WIDX_W-1:0];
                    wr_data         = rdata_reg | (WORD_W'(1) << info.low_clear);
                    free_next       = free_reg - COUNT_ONE;
                    res_addr_next   = ADDR_W'(alloc_page) << PAGE_SHIFT;
                    res_status_next = ST_DONE;
                    state_next      = S_RESP;
                end
                else if (info.found)
                begin
                    res_status_next = ST_NO_PAGE;
                    state_next      = S_RESP;
                end
                else
                begin
                    word_next  = word_reg + WORD_ONE;
                    state_next = S_ALLOC_RD;
                end
            end

            // free: clear the bit only if it is set
            S_FREE_RD:
            begin
                rd_addr    = pos_word;
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                state_next = S_RESP;
                if (rdata_reg[pos_reg[BIT_W-1:0]])
                begin
                    mem_we          = 1'b1;
                    wr_addr         = pos_word;
                    wr_data         = rdata_reg & ~(WORD_W'(1) << pos_reg[BIT_W-1:0]);
                    res_status_next = ST_DONE;
                    if (free_reg != COUNT_MAX)
                    begin
                        free_next = free_reg + COUNT_ONE;
                    end
                end
            end

            // reserve: clip the region end at the managed pages
            S_RES_SETUP:
            begin
                last_next       = res_last;
                res_status_next = ST_DONE;
                if (pos_reg >= res_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_RES_RD;
                end
            end

            S_RES_RD:
            begin
                rd_addr    = pos_word;
                mask_next  = lo_mask & hi_mask;
                state_next = S_RES_CHK;
            end

            S_RES_CHK:
            begin
                mem_we    = 1'b1;
                wr_addr   = pos_word;
                wr_data   = rdata_reg | mask_reg;
                free_next = (free_reg > add_count) ? (free_reg - add_count) : '0;
                pos_next  = next_base;
                if (next_base >= last_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_RES_RD;
                end
            end

            // hand the result to the output register
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    page_address_next = res_addr_reg;
                    status_next       = res_status_reg;
                    free_count_next   = free_reg;
                    used_count_next   = (lim_ext > EXT_W'(free_reg))
                                        ? COUNT_W'(lim_ext - EXT_W'(free_reg)) : '0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;
    assign free_count   = free_count_reg;
    assign used_count   = used_count_reg;

    // checks
    `PBA_ASSERT_SAME(a_fail_no_addr, out_valid && status != ST_DONE, page_address == '0, "stray address")
    `PBA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second transaction while busy")
    `PBA_ASSERT_SAME(a_res_range, state_reg == S_RES_CHK, pos_reg < last_reg, "reserve past region end")

endmodule

[tb/tb_page_bitmap_allocator.sv]
`timescale 1ns / 1ps

module tb_page_bitmap_allocator;
    import pba_pkg::*;

    localparam int PAGES    = NUM_PAGES_DEF;
    localparam int PG_SHIFT = PAGE_SHIFT_DEF;

    // request code with no meaning to the block
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [ADDR_W-1:0] PAGE_OFFSET_MASK = (32'd1 << PG_SHIFT) - 32'd1;
    localparam longint unsigned   PAGE_BYTES       = 64'd1 << PG_SHIFT;

    // cycles to let pass once nothing is outstanding
    localparam int SETTLE = 4;
    localparam int TAIL   = 50;

    // generous cap on the length of the whole run
    localparam int unsigned CYCLE_LIMIT = 4000000;

    localparam int PHASE_COUNT = 11;

    typedef struct packed {
        logic [ADDR_W-1:0]   page_address;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_count;
        logic [COUNT_W-1:0]  used_count;
    } alloc_reply_t;

    // bitmap and free count mirror, plus the replies still owed by the block
    class alloc_scoreboard;
        bit               page_taken [PAGES];
        int unsigned      free_total;
        logic [COUNT_W-1:0] page_limit_reg;
        alloc_reply_t     pending_replies [$];
        int               error_count;

        function new();
            foreach (page_taken[i])
                page_taken[i] = 1'b1;
            free_total     = 0;
            page_limit_reg = PAGE_LIMIT_RESET;
            error_count    = 0;
        endfunction

        function void set_page_limit(logic [COUNT_W-1:0] value);
            page_limit_reg = value;
        endfunction

        function int unsigned managed_pages();
            return (page_limit_reg > PAGES) ? PAGES : page_limit_reg;
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction

        // update the bitmap mirror for one request and queue the reply it owes
        function void apply_request(logic [TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                    logic [ADDR_W-1:0] len);
            int unsigned     lim;
            int unsigned     pg;
            longint unsigned first_pg;
            longint unsigned end_pg;
            longint unsigned p;
            alloc_reply_t    reply;

            lim          = managed_pages();
            reply        = '0;
            reply.status = ST_IGNORED;
            case (kind)
                REQ_ALLOC:
                begin
                    reply.status = ST_NO_PAGE;
                    if (free_total != 0) begin
                        pg = 0;
                        while (pg < lim && page_taken[pg])
                            pg++;
                        if (pg < lim) begin
                            page_taken[pg] = 1'b1;
                            free_total--;
                            reply.page_address = pg << PG_SHIFT;
                            reply.status       = ST_DONE;
                        end
                    end
                end
                REQ_FREE:
                begin
                    first_pg = addr >> PG_SHIFT;
                    if (addr != 0 && first_pg < lim && page_taken[first_pg]) begin
                        page_taken[first_pg] = 1'b0;
                        if (free_total < COUNT_MAX)
                            free_total++;
                        reply.status = ST_DONE;
                    end
                end
                REQ_RESERVE:
                begin
                    // region end in 64 bits, so it never wraps, then clipped to the map
                    first_pg = longint'(addr) >> PG_SHIFT;
                    end_pg   = (longint'(addr) + longint'(len) + PAGE_BYTES - 1) >> PG_SHIFT;
                    if (end_pg > lim)
                        end_pg = lim;
                    for (p = first_pg; p < end_pg; p++) begin
                        if (!page_taken[p]) begin
                            page_taken[p] = 1'b1;
                            if (free_total > 0)
                                free_total--;
                        end
                    end
                    reply.status = ST_DONE;
                end
                default:
                begin
                    reply.status = ST_IGNORED;
                end
            endcase
            reply.free_count = free_total[COUNT_W-1:0];
            reply.used_count = (lim > free_total) ? COUNT_W'(lim - free_total) : '0;
            pending_replies.push_back(reply);
        endfunction

        function void compare_field(string field, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                error_count++;
            end
        endfunction

        function void check_reply(alloc_reply_t got);
            alloc_reply_t want;

            if (pending_replies.size() == 0) begin
                $display("%0t: reply with no request outstanding, expected none, actual %h",
                         $time, got);
                error_count++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("page_address", want.page_address, got.page_address);
            compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
            compare_field("free_count", ADDR_W'(want.free_count), ADDR_W'(got.free_count));
            compare_field("used_count", ADDR_W'(want.used_count), ADDR_W'(got.used_count));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [TYPE_W-1:0]   req_type;
    logic [ADDR_W-1:0]   byte_address;
    logic [ADDR_W-1:0]   region_length;
    logic                out_valid;
    logic                out_ready;
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  used_count;

    alloc_scoreboard sb;
    int unsigned     cycle_count   = 0;
    int              receiver_hold = 0;
    bit              steady_flow   = 1'b0;

    // map sizes per phase, extremes included, and the random items each gets
    int unsigned phase_limit [PHASE_COUNT] =
        '{64, 0, 1, 1000, 31, 33, 65535, 512, 32768, 100, 4096};
    int          phase_items [PHASE_COUNT] =
        '{250, 60, 80, 250, 100, 100, 50, 250, 50, 250, 160};

    page_bitmap_allocator #(
        .NUM_PAGES  (PAGES),
        .PAGE_SHIFT (PG_SHIFT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .byte_address  (byte_address),
        .region_length (region_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .page_address  (page_address),
        .status        (status),
        .free_count    (free_count),
        .used_count    (used_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run cap
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_page_bitmap_allocator: errors");
            $finish;
        end
    end

    // reply side: random back-pressure, long hold-offs on request
    initial
    begin
        alloc_reply_t seen;
        int           gap;
        int           hold_left;

        out_ready = 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (receiver_hold > 0) begin
                hold_left     = receiver_hold;
                receiver_hold = 0;
                out_ready <= 1'b0;
                while (hold_left > 0) begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            gap = steady_flow ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            seen.page_address = page_address;
            seen.status       = status;
            seen.free_count   = free_count;
            seen.used_count   = used_count;
            sb.check_reply(seen);
        end
    end

    // one request transaction, preceded by a random idle gap
    task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                                input logic [ADDR_W-1:0] len);
        int gap;

        gap = steady_flow ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        byte_address  <= addr;
        region_length <= len;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.apply_request(kind, addr, len);
    endtask

    // mostly pages around the managed range, some wild addresses and unknown codes
    task automatic send_random_request();
        int unsigned       lim;
        int unsigned       reach;
        int unsigned       pick;
        int unsigned       pg;
        logic [TYPE_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;

        lim   = sb.managed_pages();
        reach = lim + lim / 4 + 8;
        pick  = $urandom_range(0, 99);
        pg    = $urandom_range(0, reach - 1);
        addr  = $urandom;
        len   = $urandom;
        if (pick < 35) begin
            kind = REQ_ALLOC;
        end
        else if (pick < 70) begin
            kind = REQ_FREE;
            if (pick < 62)
                addr = (pg << PG_SHIFT) | (addr & PAGE_OFFSET_MASK);
            else if (pick < 65)
                addr = '0;
        end
        else if (pick < 92) begin
            kind = REQ_RESERVE;
            if (pick < 88)
                addr = (pg << PG_SHIFT) | (addr & PAGE_OFFSET_MASK);
            if (pick < 82)
                len = $urandom_range(0, 3 << PG_SHIFT);
            else if (pick < 88)
                len = $urandom_range(0, 40 << PG_SHIFT);
        end
        else begin
            kind = REQ_UNKNOWN;
        end
        send_request(kind, addr, len);
    endtask

    // stop offering and wait until every reply is in
    task automatic wait_for_replies(input int settle);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_page_limit(input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_page_limit(value);
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = PAGE_LIMIT_RESET;
        in_valid      = 1'b0;
        req_type      = REQ_ALLOC;
        byte_address  = '0;
        region_length = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests on the full map left at its reset size
        send_request(REQ_ALLOC, '0, '0);                         // free count still zero
        send_request(REQ_FREE, '0, '0);                          // address zero
        send_request(REQ_FREE, 32'h0000_0FFF, '0);               // page zero, top offset
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // page zero, address 0
        send_request(REQ_FREE, 32'h0000_1000, '0);
        send_request(REQ_FREE, 32'h0000_1000, '0);               // bit already clear
        send_request(REQ_FREE, 32'hFFFF_FFFF, '0);               // far above the map
        send_request(REQ_FREE, 32'h0800_0000, '0);               // first page past the map
        send_request(REQ_FREE, 32'h07FF_F000, '0);               // top page
        send_request(REQ_ALLOC, '0, '0);                         // page one
        send_request(REQ_ALLOC, '0, '0);                         // top page, full scan
        send_request(REQ_ALLOC, '0, '0);                         // nothing left
        send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_RESERVE, '0, '0);                       // empty region
        send_request(REQ_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF); // end past 32 bits
        send_request(REQ_FREE, 32'h0000_2000, '0);
        send_request(REQ_FREE, 32'h0000_3000, '0);
        send_request(REQ_FREE, 32'h0000_4000, '0);
        send_request(REQ_RESERVE, 32'h0000_2001, '0);            // zero length, one page
        send_request(REQ_RESERVE, 32'h0000_3000, 32'h0000_1001); // pages three and four
        send_request(REQ_FREE, 32'h0000_5123, '0);
        send_request(REQ_RESERVE, '0, 32'hFFFF_FFFF);            // whole map
        send_request(REQ_FREE, 32'h000C_8000, '0);               // page 200, above small maps

        // random traffic over a series of map sizes, each opened by an allocation
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_for_replies(SETTLE);
            write_page_limit(COUNT_W'(phase_limit[ph]));
            send_request(REQ_ALLOC, $urandom, $urandom);
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (ph == 0 && n == 125)
                    wait_for_replies(SETTLE);
                if (ph == 3 && n == 40)
                    receiver_hold = 400;
                steady_flow = (ph == 7 && n < 120);
                send_random_request();
            end
        end

        wait_for_replies(TAIL);
        if (sb.error_count == 0)
            $display("tb_page_bitmap_allocator: clean");
        else
            $display("tb_page_bitmap_allocator: errors");
        $finish;
    end

endmodule
